// ----- rtl/core/uartrb_pkg.sv -----
// ----------------------------------------------------------------------------
// uartrb_pkg
// Shared request codes and pipeline types for the serial port byte queues.
// ----------------------------------------------------------------------------
package uartrb_pkg;

   // request codes carried on req_type
   typedef enum logic [2:0] {
      REQ_RX_BYTE    = 3'd0,
      REQ_HOST_READ  = 3'd1,
      REQ_HOST_WRITE = 3'd2,
      REQ_TX_READY   = 3'd3,
      REQ_RX_FLUSH   = 3'd4
   } req_code_type;

   // width of the status count fields
   localparam int unsigned CountWidth = 6;

   // bookkeeping of a word between memory access and response register
   typedef struct packed {
      logic valid;
      logic pop_rx;
      logic pop_tx;
      logic accepted;
   } stage_type;

endpackage

// ----- rtl/core/uart_rx_tx_ring_buffers.sv -----
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_buffers
// Receive and transmit byte rings for a serial port, one spare slot each.
// An accepted request word is held in stage one (s1_ff), then moves into the
// response register behind rsp_valid. Throughput: one request word per cycle
// while no response stall holds stage one; each word makes at most one access
// to one ring memory (single port, registered read); pointers are flip-flops.
// Reset: pointers, transmit interrupt enable and pipeline valids are cleared;
// the ring memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module uart_rx_tx_ring_buffers
   import uartrb_pkg::*;
#(
   parameter int unsigned RX_CAPACITY = 63,
   parameter int unsigned TX_CAPACITY = 63
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [2:0]            req_type,
   input  logic [7:0]            req_data_in,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_data_out,
   output logic                  rsp_data_valid,
   output logic                  rsp_accepted,
   output logic [CountWidth-1:0] rsp_rx_free,
   output logic [CountWidth-1:0] rsp_rx_used,
   output logic                  rsp_tx_irq_on
);

   localparam int unsigned RxSlots = RX_CAPACITY + 1;
   localparam int unsigned TxSlots = TX_CAPACITY + 1;
   localparam int unsigned RxPw    = $clog2(RxSlots);
   localparam int unsigned TxPw    = $clog2(TxSlots);
   localparam logic [RxPw-1:0] RxLast = RxPw'(RxSlots - 1);
   localparam logic [TxPw-1:0] TxLast = TxPw'(TxSlots - 1);

   // ring storage
   logic [7:0] rx_mem [RxSlots];
   logic [7:0] tx_mem [TxSlots];
   logic [7:0] rx_rd_ff;
   logic [7:0] tx_rd_ff;

   // pointers and enable
   logic [RxPw-1:0] rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic [TxPw-1:0] tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in;
   logic            tx_irq_ff, tx_irq_in;

   // pipeline
   stage_type s1_ff, s1_in;
   logic      rsp_valid_ff;
   logic [7:0] rsp_data_ff;
   logic      rsp_dvalid_ff, rsp_acc_ff, rsp_irq_ff;
   logic [CountWidth-1:0] rsp_free_ff, rsp_used_ff;

   logic req_take, advance;
   logic rx_we, rx_re, tx_we, tx_re;
   logic [RxPw-1:0] rx_head_nxt, rx_tail_nxt;
   logic [TxPw-1:0] tx_head_nxt, tx_tail_nxt;
   logic [8:0] rx_used9, rx_free9;

   // handshake: stage one moves on when the response register is empty or taken
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_ff.valid && !advance;
   assign req_take  = req_valid && !req_stall;

   // ring pointer successors
   assign rx_head_nxt = (rx_head_ff == RxLast) ? '0 : rx_head_ff + 1'b1;
   assign rx_tail_nxt = (rx_tail_ff == RxLast) ? '0 : rx_tail_ff + 1'b1;
   assign tx_head_nxt = (tx_head_ff == TxLast) ? '0 : tx_head_ff + 1'b1;
   assign tx_tail_nxt = (tx_tail_ff == TxLast) ? '0 : tx_tail_ff + 1'b1;

   // request decode and pointer update
   always_comb begin
      rx_head_in = rx_head_ff;
      rx_tail_in = rx_tail_ff;
      tx_head_in = tx_head_ff;
      tx_tail_in = tx_tail_ff;
      tx_irq_in  = tx_irq_ff;
      rx_we = 1'b0;
      rx_re = 1'b0;
      tx_we = 1'b0;
      tx_re = 1'b0;
      s1_in = '0;
      s1_in.valid = req_take;
      if (req_take) begin
         case (req_type)
            REQ_RX_BYTE: begin
               if (rx_head_nxt != rx_tail_ff) begin
                  rx_we          = 1'b1;
                  rx_head_in     = rx_head_nxt;
                  s1_in.accepted = 1'b1;
               end
            end
            REQ_HOST_READ: begin
               if (rx_head_ff != rx_tail_ff) begin
                  rx_re        = 1'b1;
                  rx_tail_in   = rx_tail_nxt;
                  s1_in.pop_rx = 1'b1;
               end
            end
            REQ_HOST_WRITE: begin
               if (tx_head_nxt != tx_tail_ff) begin
                  tx_we          = 1'b1;
                  tx_head_in     = tx_head_nxt;
                  s1_in.accepted = 1'b1;
               end
               tx_irq_in = 1'b1;
            end
            REQ_TX_READY: begin
               if (tx_tail_ff != tx_head_ff) begin
                  tx_re        = 1'b1;
                  tx_tail_in   = tx_tail_nxt;
                  s1_in.pop_tx = 1'b1;
               end else begin
                  tx_irq_in = 1'b0;
               end
            end
            REQ_RX_FLUSH: begin
               rx_tail_in = rx_head_ff;
            end
            default: begin
            end
         endcase
      end
   end

   // receive ring memory
   always_ff @(posedge clock) begin
      if (rx_we) begin
         rx_mem[rx_head_ff] <= req_data_in;
      end
      if (rx_re) begin
         rx_rd_ff <= rx_mem[rx_tail_ff];
      end
   end

   // transmit ring memory
   always_ff @(posedge clock) begin
      if (tx_we) begin
         tx_mem[tx_head_ff] <= req_data_in;
      end
      if (tx_re) begin
         tx_rd_ff <= tx_mem[tx_tail_ff];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_head_ff <= '0;
         rx_tail_ff <= '0;
         tx_head_ff <= '0;
         tx_tail_ff <= '0;
         tx_irq_ff  <= 1'b0;
      end else begin
         rx_head_ff <= rx_head_in;
         rx_tail_ff <= rx_tail_in;
         tx_head_ff <= tx_head_in;
         tx_tail_ff <= tx_tail_in;
         tx_irq_ff  <= tx_irq_in;
      end
   end

   // stage one: pointers already hold the post-step values here
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
      end else if (req_take) begin
         s1_ff <= s1_in;
      end else if (advance) begin
         s1_ff <= '0;
      end
   end

   // receive fill count and free space
   always_comb begin
      logic [8:0] head9;
      logic [8:0] tail9;
      head9 = 9'(rx_head_ff);
      tail9 = 9'(rx_tail_ff);
      if (head9 >= tail9) begin
         rx_used9 = head9 - tail9;
      end else begin
         rx_used9 = head9 + 9'(RxSlots) - tail9;
      end
      rx_free9 = 9'(RX_CAPACITY) - rx_used9;
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_ff.valid) begin
         if (s1_ff.pop_rx) begin
            rsp_data_ff <= rx_rd_ff;
         end else if (s1_ff.pop_tx) begin
            rsp_data_ff <= tx_rd_ff;
         end else begin
            rsp_data_ff <= '0;
         end
         rsp_dvalid_ff <= s1_ff.pop_rx || s1_ff.pop_tx;
         rsp_acc_ff    <= s1_ff.accepted;
         rsp_free_ff   <= rx_free9[CountWidth-1:0];
         rsp_used_ff   <= rx_used9[CountWidth-1:0];
         rsp_irq_ff    <= tx_irq_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data_out   = rsp_data_ff;
   assign rsp_data_valid = rsp_dvalid_ff;
   assign rsp_accepted   = rsp_acc_ff;
   assign rsp_rx_free    = rsp_free_ff;
   assign rsp_rx_used    = rsp_used_ff;
   assign rsp_tx_irq_on  = rsp_irq_ff;

   // checks
   a_rx_not_overfull: assert property (@(posedge clock) disable iff (reset)
      rx_used9 <= 9'(RX_CAPACITY))
      else $error("receive ring holds more than its capacity");

   a_counts_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         CountWidth'(rsp_used_ff + rsp_free_ff) == CountWidth'(RX_CAPACITY))
      else $error("receive free and used counts disagree");

   a_no_pop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_dvalid_ff) |-> rsp_data_ff == '0)
      else $error("data shown without a popped byte");

   a_push_pop_excl: assert property (@(posedge clock) disable iff (reset)
      s1_ff.valid |-> !(s1_ff.accepted && (s1_ff.pop_rx || s1_ff.pop_tx)))
      else $error("one word both pushed and popped");

endmodule

// ----- test/uart_rx_tx_ring_buffers_tb.sv -----
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_buffers_tb
// Self-checking bench for the serial port receive and transmit byte rings.
// Every request word that is accepted updates a software copy of both rings
// and of the transmit interrupt enable. The copy yields the status word that
// is due, and each response word is compared field by field, in order. After
// a short directed opening, random bursts fill and drain the rings under
// several patterns of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module uart_rx_tx_ring_buffers_tb;
   import uartrb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RX_CAP   = 63;
   localparam int unsigned TX_CAP   = 63;
   localparam int unsigned RX_SLOTS = RX_CAP + 1;
   localparam int unsigned TX_SLOTS = TX_CAP + 1;
   localparam int unsigned RX_PW    = $clog2(RX_SLOTS);
   localparam int unsigned TX_PW    = $clog2(TX_SLOTS);

   // request codes outside the package enum, which the block must ignore
   localparam logic [2:0] FIRST_UNUSED_CODE = 3'd5;
   localparam logic [2:0] LAST_UNUSED_CODE  = 3'd7;

   localparam int unsigned RANDOM_WORDS   = 2000;
   localparam int unsigned PHASE_WORDS    = RANDOM_WORDS / 4;
   localparam int unsigned DRAIN_CYCLES   = 20;
   localparam int unsigned CYCLE_LIMIT    = 400000;

   // burst flavors of the random part
   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_EVEN
   } burst_mix_type;

   // one response word as the block reports it
   typedef struct packed {
      logic [7:0]            data_out;
      logic                  data_valid;
      logic                  accepted;
      logic [CountWidth-1:0] rx_free;
      logic [CountWidth-1:0] rx_used;
      logic                  tx_irq_on;
   } status_word_type;

   // -------------------------------------------------------------------------
   // ring copy and in-order status check
   // -------------------------------------------------------------------------
   class ring_scoreboard;
      logic [7:0]      rx_ring [RX_SLOTS];
      logic [7:0]      tx_ring [TX_SLOTS];
      int unsigned     rx_wr, rx_rd, tx_wr, tx_rd;
      logic            irq_en;
      status_word_type due_q[$];
      int unsigned     error_count;
      int unsigned     words_in, words_out;
      int unsigned     rx_drops, tx_refusals, empty_pops, irq_clears, flushes;

      function new();
         rx_wr = 0;
         rx_rd = 0;
         tx_wr = 0;
         tx_rd = 0;
         irq_en = 1'b0;
         error_count = 0;
         words_in = 0;
         words_out = 0;
         rx_drops = 0;
         tx_refusals = 0;
         empty_pops = 0;
         irq_clears = 0;
         flushes = 0;
      endfunction

      // apply one accepted request word and queue the status it causes
      function void note_request(logic [2:0] code, logic [7:0] din);
         status_word_type due;
         int unsigned     nxt, used;
         due = '0;
         words_in++;
         case (code)
            REQ_RX_BYTE: begin
               nxt = (rx_wr + 1) % RX_SLOTS;
               if (nxt != rx_rd) begin
                  rx_ring[rx_wr[RX_PW-1:0]] = din;
                  rx_wr = nxt;
                  due.accepted = 1'b1;
               end else begin
                  rx_drops++;
               end
            end
            REQ_HOST_READ: begin
               if (rx_wr != rx_rd) begin
                  due.data_out = rx_ring[rx_rd[RX_PW-1:0]];
                  due.data_valid = 1'b1;
                  rx_rd = (rx_rd + 1) % RX_SLOTS;
               end else begin
                  empty_pops++;
               end
            end
            REQ_HOST_WRITE: begin
               nxt = (tx_wr + 1) % TX_SLOTS;
               if (nxt != tx_rd) begin
                  tx_ring[tx_wr[TX_PW-1:0]] = din;
                  tx_wr = nxt;
                  due.accepted = 1'b1;
               end else begin
                  tx_refusals++;
               end
               // a refused write still arms the interrupt
               irq_en = 1'b1;
            end
            REQ_TX_READY: begin
               if (tx_rd != tx_wr) begin
                  due.data_out = tx_ring[tx_rd[TX_PW-1:0]];
                  due.data_valid = 1'b1;
                  tx_rd = (tx_rd + 1) % TX_SLOTS;
               end else begin
                  irq_en = 1'b0;
                  irq_clears++;
               end
            end
            REQ_RX_FLUSH: begin
               rx_rd = rx_wr;
               flushes++;
            end
            default: begin
            end
         endcase
         // status fields, masked to the count width
         used = (rx_wr + RX_SLOTS - rx_rd) % RX_SLOTS;
         due.rx_used = used[CountWidth-1:0];
         due.rx_free = CountWidth'(RX_CAP - used);
         due.tx_irq_on = irq_en;
         due_q.push_back(due);
      endfunction

      function void field_check(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s mismatch: expected %0h, actual %0h", field, want, got);
            error_count++;
         end
      endfunction

      // compare one response word with the oldest queued status
      function void check_status(status_word_type got);
         status_word_type want;
         words_out++;
         if (due_q.size() == 0) begin
            $error("response word with nothing outstanding: %0h", got);
            error_count++;
         end else begin
            want = due_q.pop_front();
            field_check("data_out", want.data_out, got.data_out);
            field_check("data_valid", want.data_valid, got.data_valid);
            field_check("accepted", want.accepted, got.accepted);
            field_check("rx_free", want.rx_free, got.rx_free);
            field_check("rx_used", want.rx_used, got.rx_used);
            field_check("tx_irq_on", want.tx_irq_on, got.tx_irq_on);
         end
      endfunction

      function int unsigned pending();
         return due_q.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // signals and block under test
   // -------------------------------------------------------------------------
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [2:0]            req_type = '0;
   logic [7:0]            req_data_in = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [7:0]            rsp_data_out;
   logic                  rsp_data_valid;
   logic                  rsp_accepted;
   logic [CountWidth-1:0] rsp_rx_free;
   logic [CountWidth-1:0] rsp_rx_used;
   logic                  rsp_tx_irq_on;

   int unsigned           send_idle_pct = 0;
   int unsigned           stall_pct = 0;
   int unsigned           cycle_count = 0;

   ring_scoreboard        ring_sb = new();

   uart_rx_tx_ring_buffers #(
      .RX_CAPACITY(RX_CAP),
      .TX_CAPACITY(TX_CAP)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_data_in   (req_data_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data_out  (rsp_data_out),
      .rsp_data_valid(rsp_data_valid),
      .rsp_accepted  (rsp_accepted),
      .rsp_rx_free   (rsp_rx_free),
      .rsp_rx_used   (rsp_rx_used),
      .rsp_tx_irq_on (rsp_tx_irq_on)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // cycle counter and watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d words outstanding",
               cycle_count, ring_sb.pending());
      $display("uart_rx_tx_ring_buffers verification failed");
      $finish;
   end

   // receiver stall, rolled every cycle
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         ring_sb.check_status('{rsp_data_out, rsp_data_valid, rsp_accepted,
                                rsp_rx_free, rsp_rx_used, rsp_tx_irq_on});
      end
   end

   // present one request word and hold it until accepted
   task automatic send_word(logic [2:0] code, logic [7:0] din);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= code;
      req_data_in <= din;
      do @(posedge clock); while (req_stall);
      ring_sb.note_request(code, din);
   endtask

   // pick a request code weighted by burst flavor
   function automatic logic [2:0] pick_code(burst_mix_type mix);
      int unsigned r, w;
      r = $urandom_range(0, 99);
      w = $urandom_range(0, 99);
      if (r < 2) return 3'($urandom_range(FIRST_UNUSED_CODE, LAST_UNUSED_CODE));
      if (r < 5) return REQ_RX_FLUSH;
      case (mix)
         MIX_FILL: begin
            if (w < 45) return REQ_RX_BYTE;
            if (w < 90) return REQ_HOST_WRITE;
            if (w < 95) return REQ_HOST_READ;
            return REQ_TX_READY;
         end
         MIX_DRAIN: begin
            if (w < 45) return REQ_HOST_READ;
            if (w < 90) return REQ_TX_READY;
            if (w < 95) return REQ_RX_BYTE;
            return REQ_HOST_WRITE;
         end
         default: begin
            if (w < 25) return REQ_RX_BYTE;
            if (w < 50) return REQ_HOST_READ;
            if (w < 75) return REQ_HOST_WRITE;
            return REQ_TX_READY;
         end
      endcase
   endfunction

   // random bursts under one idling pattern, with some quiet bursts
   task automatic run_phase(int unsigned idle_pct, int unsigned hold_pct);
      int unsigned   sent, burst_len, k;
      burst_mix_type mix;
      logic [2:0]    code;
      sent = 0;
      while (sent < PHASE_WORDS) begin
         burst_len = $urandom_range(1, 100);
         mix = burst_mix_type'($urandom_range(0, 2));
         if ($urandom_range(0, 3) == 0) begin
            send_idle_pct = 0;
            stall_pct = 0;
         end else begin
            send_idle_pct = idle_pct;
            stall_pct = hold_pct;
         end
         for (k = 0; k < burst_len && sent < PHASE_WORDS; k++) begin
            code = pick_code(mix);
            send_word(code, 8'($urandom_range(0, 255)));
            sent++;
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty pops, pushes of extreme bytes, ignored codes, flush
      send_word(REQ_HOST_READ, 8'h00);
      send_word(REQ_TX_READY, 8'hff);
      send_word(REQ_RX_FLUSH, 8'h00);
      send_word(REQ_RX_BYTE, 8'h00);
      send_word(REQ_RX_BYTE, 8'hff);
      send_word(REQ_RX_BYTE, 8'ha5);
      send_word(REQ_HOST_READ, 8'hff);
      send_word(REQ_HOST_READ, 8'h00);
      send_word(REQ_HOST_READ, 8'h00);
      send_word(REQ_HOST_READ, 8'h00);
      send_word(REQ_HOST_WRITE, 8'h00);
      send_word(REQ_HOST_WRITE, 8'hff);
      send_word(REQ_TX_READY, 8'h00);
      send_word(REQ_TX_READY, 8'h00);
      send_word(REQ_TX_READY, 8'h00);
      send_word(FIRST_UNUSED_CODE, 8'hff);
      send_word(FIRST_UNUSED_CODE + 3'd1, 8'h5a);
      send_word(LAST_UNUSED_CODE, 8'hff);
      send_word(REQ_RX_BYTE, 8'h5a);
      send_word(REQ_RX_BYTE, 8'h3c);
      send_word(REQ_RX_FLUSH, 8'hff);
      send_word(REQ_HOST_READ, 8'h00);
      send_word(REQ_HOST_WRITE, 8'h81);
      send_word(REQ_TX_READY, 8'h00);

      // random: no idling, sender idle, receiver stall, both
      run_phase(0, 0);
      run_phase(68, 0);
      run_phase(0, 68);
      run_phase(13, 13);

      req_valid <= 1'b0;
      while (ring_sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d request words, %0d response words checked in %0d cycles",
               ring_sb.words_in, ring_sb.words_out, cycle_count);
      $display("rx drops %0d, tx refusals %0d, empty pops %0d, irq clears %0d, flushes %0d",
               ring_sb.rx_drops, ring_sb.tx_refusals, ring_sb.empty_pops,
               ring_sb.irq_clears, ring_sb.flushes);
      if (ring_sb.error_count == 0 && ring_sb.pending() == 0) begin
         $display("uart_rx_tx_ring_buffers verification clean");
      end else begin
         $display("uart_rx_tx_ring_buffers verification failed");
      end
      $finish;
   end

endmodule

// ----- uart_rx_tx_ring_buffers.f -----
rtl/core/uartrb_pkg.sv
rtl/core/uart_rx_tx_ring_buffers.sv
test/uart_rx_tx_ring_buffers_tb.sv
